/* src/fwpa_pkg.sv */
// Shared types and codes for the firmware page assembler.
package fwpa_pkg;

  // Input operation codes.
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_ERASE   = 2'd1;
  localparam logic [1:0] KIND_PROGRAM = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SESSION = 2'd1;
  localparam logic [1:0] ST_BAD_OFFSET = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ERASE,
    S_PROG,
    S_STATUS
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_item;
    logic       commit_start;
    logic       commit_write;
    logic       page_advance;
    logic       end_clear;
    logic       idx_clear;
    logic       idx_inc;
    logic       emit;
    logic [1:0] emit_kind;
    logic [1:0] emit_status;
    logic       emit_last;
  } fwpa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       session_open;
    logic       write_ok;
    logic       fill_full_after;
    logic       fill_zero;
    logic       out_free;
    logic       idx_last;
  } fwpa_stat_t;

endpackage

/* src/fwpa_ctrl.sv */
// Controller state machine of the firmware page assembler.
module fwpa_ctrl
  import fwpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  fwpa_stat_t stat,
  output fwpa_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.emit_kind   = KIND_STATUS;
    cmd.emit_status = ST_OK;
    in_tready       = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end

      S_EXEC: begin
        case (stat.op)
          OP_START: begin
            if (stat.out_free) begin
              cmd.commit_start = 1'b1;
              cmd.emit         = 1'b1;
              cmd.emit_last    = 1'b1;
              state_nxt        = S_IDLE;
            end
          end
          OP_WRITE: begin
            if (!stat.session_open) begin
              if (stat.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_NO_SESSION;
                cmd.emit_last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else if (!stat.write_ok) begin
              if (stat.out_free) begin
                cmd.emit        = 1'b1;
                cmd.emit_status = ST_BAD_OFFSET;
                cmd.emit_last   = 1'b1;
                state_nxt       = S_IDLE;
              end
            end else if (stat.fill_full_after) begin
              // The word completes the page: store it and flush.
              cmd.commit_write = 1'b1;
              cmd.idx_clear    = 1'b1;
              state_nxt        = S_ERASE;
            end else if (stat.out_free) begin
              cmd.commit_write = 1'b1;
              cmd.emit         = 1'b1;
              cmd.emit_last    = 1'b1;
              state_nxt        = S_IDLE;
            end
          end
          OP_END: begin
            if (stat.session_open && !stat.fill_zero) begin
              cmd.idx_clear = 1'b1;
              state_nxt     = S_ERASE;
            end else if (stat.out_free) begin
              cmd.end_clear = 1'b1;
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          default: begin
            if (stat.out_free) begin
              cmd.emit      = 1'b1;
              cmd.emit_last = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        endcase
      end

      S_ERASE: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_ERASE;
          state_nxt     = S_PROG;
        end
      end

      S_PROG: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_PROGRAM;
          cmd.idx_inc   = 1'b1;
          if (stat.idx_last) begin
            cmd.page_advance = 1'b1;
            state_nxt        = S_STATUS;
          end
        end
      end

      S_STATUS: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.end_clear = (stat.op == OP_END);
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* src/fwpa_datapath.sv */
// Datapath of the firmware page assembler: session state, page buffer and output register.
module fwpa_datapath
  import fwpa_pkg::*;
#(
  parameter int PAGE_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  fwpa_cmd_t   cmd,
  output fwpa_stat_t  stat
);

  localparam int          FW         = $clog2(PAGE_WORDS + 1);
  localparam int          IW         = $clog2(PAGE_WORDS);
  localparam logic [31:0] PAGE_BYTES = 32'(PAGE_WORDS * 4);

  logic [31:0]   target_base_r;
  logic          session_open_r;
  logic [31:0]   page_address_r;
  logic [FW-1:0] fill_count_r;
  logic [IW-1:0] idx_r;

  logic [1:0]    op_r;
  logic [31:0]   word_r;
  logic [31:0]   offset_r;

  logic [31:0]   page_mem [PAGE_WORDS];
  logic [31:0]   rdata_r;
  logic [IW-1:0] rd_addr;

  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [31:0]   out_addr_r;
  logic [31:0]   out_data_r;
  logic [1:0]    out_status_r;
  logic          out_last_r;

  logic [31:0]   expected_offset;
  logic [31:0]   emit_addr;
  logic [31:0]   emit_data;

  assign expected_offset = page_address_r - target_base_r + (32'(fill_count_r) << 2);

  assign stat.op              = op_r;
  assign stat.session_open    = session_open_r;
  assign stat.write_ok        = (offset_r == expected_offset) &&
                                (fill_count_r < FW'(PAGE_WORDS));
  assign stat.fill_full_after = (fill_count_r == FW'(PAGE_WORDS - 1));
  assign stat.fill_zero       = (fill_count_r == '0);
  assign stat.out_free        = !out_valid_r || out_tready;
  assign stat.idx_last        = (idx_r == IW'(PAGE_WORDS - 1));

  // Read one ahead while a program transaction leaves; hold the address on a stall.
  always_comb begin
    rd_addr = idx_r;
    if (cmd.emit && (cmd.emit_kind == KIND_PROGRAM) && !stat.idx_last) begin
      rd_addr = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_write) begin
      page_mem[fill_count_r[IW-1:0]] <= word_r;
    end
    rdata_r <= page_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_r     <= in_tuser;
      word_r   <= in_tdata[31:0];
      offset_r <= in_tdata[63:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_base_r  <= '0;
      session_open_r <= 1'b0;
      page_address_r <= '0;
      fill_count_r   <= '0;
      idx_r          <= '0;
    end else begin
      if (cfg_we) begin
        target_base_r <= cfg_wdata;
      end
      if (cmd.commit_start) begin
        session_open_r <= 1'b1;
        page_address_r <= target_base_r;
        fill_count_r   <= '0;
      end
      if (cmd.commit_write) begin
        fill_count_r <= fill_count_r + 1'b1;
      end
      if (cmd.page_advance) begin
        page_address_r <= page_address_r + PAGE_BYTES;
        fill_count_r   <= '0;
      end
      if (cmd.end_clear) begin
        session_open_r <= 1'b0;
        page_address_r <= '0;
        fill_count_r   <= '0;
      end
      if (cmd.idx_clear) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= stat.idx_last ? '0 : idx_r + 1'b1;
      end
    end
  end

  // Words past the fill count belong to the zero padding of a closing page.
  always_comb begin
    emit_addr = '0;
    emit_data = '0;
    case (cmd.emit_kind)
      KIND_ERASE: begin
        emit_addr = page_address_r;
      end
      KIND_PROGRAM: begin
        emit_addr = page_address_r + (32'(idx_r) << 2);
        emit_data = (FW'(idx_r) < fill_count_r) ? rdata_r : '0;
      end
      default: begin
        emit_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= cmd.emit_kind;
      out_addr_r   <= emit_addr;
      out_data_r   <= emit_data;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_status_r, out_data_r, out_addr_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/firmware_page_assembler_core.sv */
// Firmware page assembler: collects update words into flash pages and issues flash commands.
//
// Input channel in_*: one transaction per update event. in_tuser carries the operation
// (start, write, end); in_tdata carries the data word and its claimed byte offset.
// Output channel out_*: erase, program and status results; out_tuser names the kind and
// out_tlast marks the status result that closes every input transaction.
// cfg_we/cfg_wdata load the byte base address of the target flash bank; write it
// only while the block is idle.
// An item is accepted in S_IDLE and checked against the session state in S_EXEC, where
// its status is loaded into the output register once that is free. A write that fills a
// page, or an end that closes a partial page, goes through S_ERASE, S_PROG and S_STATUS
// instead: an erase transaction, PAGE_WORDS program transactions read from the page
// buffer, one a cycle unless out_tready stalls, then the status. Input is held off while
// an item is at work; a stall on out_tready holds the output register and pauses the flush.
// Reset closes the session and clears the page address, fill count and base address;
// the page buffer needs no clearing since only words written in the session are read.
module firmware_page_assembler_core
  import fwpa_pkg::*;
#(
  parameter int PAGE_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // data_word [31:0], byte_offset [63:32]
  input  logic [1:0]  in_tuser,   // operation [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // flash_address [31:0], program_data [63:32],
                                  // status [65:64], zero [71:66]
  output logic [1:0]  out_tuser,  // kind [1:0]
  output logic        out_tlast
);

  fwpa_cmd_t  cmd;
  fwpa_stat_t stat;

  fwpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fwpa_datapath #(
    .PAGE_WORDS (PAGE_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

/* verif/flash_command_checker.sv */
// Checker that predicts and compares the flash command stream of the page assembler.
`timescale 1ns / 100ps
module flash_command_checker
  import fwpa_pkg::*;
#(
  parameter int PAGE_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [1:0]  status;
    logic        last;
  } flash_op_t;

  flash_op_t   due_ops[$];
  logic [31:0] bank_base;
  logic        session_live;
  logic [31:0] page_addr;
  int unsigned words_held;
  logic [31:0] page_buf [PAGE_WORDS];

  function automatic void queue_op(input logic [1:0] kind, input logic [31:0] addr,
                                   input logic [31:0] data, input logic [1:0] status,
                                   input logic last);
    flash_op_t r;
    r.kind   = kind;
    r.addr   = addr;
    r.data   = data;
    r.status = status;
    r.last   = last;
    due_ops.push_back(r);
  endfunction

  // One erase at the page address, then every word of the buffer in order.
  function automatic void flush_page();
    queue_op(KIND_ERASE, page_addr, '0, ST_OK, 1'b0);
    for (int i = 0; i < PAGE_WORDS; i++) begin
      queue_op(KIND_PROGRAM, page_addr + 32'(4 * i), page_buf[i], ST_OK, 1'b0);
    end
    page_addr  = page_addr + 32'(4 * PAGE_WORDS);
    words_held = 0;
  endfunction

  function automatic void assemble_event(input logic [1:0] op, input logic [31:0] word,
                                         input logic [31:0] offset);
    logic [31:0] want;
    // The expected offset always uses the base as it stands now.
    want = page_addr - bank_base + 32'(4 * words_held);
    if (op == OP_WRITE && !session_live) begin
      queue_op(KIND_STATUS, '0, '0, ST_NO_SESSION, 1'b1);
    end else if (op == OP_WRITE && (offset != want || words_held >= PAGE_WORDS)) begin
      queue_op(KIND_STATUS, '0, '0, ST_BAD_OFFSET, 1'b1);
    end else begin
      case (op)
        OP_START: begin
          session_live = 1'b1;
          page_addr    = bank_base;
          words_held   = 0;
          foreach (page_buf[i]) page_buf[i] = '0;
        end
        OP_WRITE: begin
          page_buf[words_held] = word;
          words_held++;
          if (words_held >= PAGE_WORDS) flush_page();
        end
        OP_END: begin
          if (session_live && words_held != 0) begin
            while (words_held < PAGE_WORDS) begin
              page_buf[words_held] = '0;
              words_held++;
            end
            flush_page();
          end
          session_live = 1'b0;
          page_addr    = '0;
          words_held   = 0;
        end
        default: ;
      endcase
      queue_op(KIND_STATUS, '0, '0, ST_OK, 1'b1);
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    flash_op_t r;
    if (!rst_n) begin
      due_ops.delete();
      bank_base    = '0;
      session_live = 1'b0;
      page_addr    = '0;
      words_held   = 0;
      mismatches   = 0;
    end else begin
      if (cfg_we) bank_base = cfg_wdata;
      if (in_tvalid && in_tready) assemble_event(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready) begin
        if (due_ops.size() == 0) begin
          mismatches++;
          $display("%0t: result mismatch: expected none, actual kind %0d data %h last %0b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          r = due_ops.pop_front();
          check_field("kind", 32'(r.kind), 32'(out_tuser));
          check_field("flash_address", r.addr, out_tdata[31:0]);
          check_field("program_data", r.data, out_tdata[63:32]);
          check_field("status", 32'(r.status), 32'(out_tdata[65:64]));
          check_field("last", 32'(r.last), 32'(out_tlast));
          check_field("padding", '0, 32'(out_tdata[71:66]));
        end
      end
    end
    outstanding <= due_ops.size();
  end

endmodule

/* verif/firmware_page_assembler_core_tb.sv */
// Testbench top for the firmware page assembler: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module firmware_page_assembler_core_tb
  import fwpa_pkg::*;
();

  localparam int          PAGE_WORDS   = 32;
  localparam int          RANDOM_ITEMS = 130;
  localparam int          SETTLE       = 4;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int mismatches;
  int outstanding;

  // Stimulus-side view of the session, used to pick offsets that will be taken or refused.
  logic [31:0] base_now  = '0;
  logic        sess_open = 1'b0;
  logic [31:0] next_off  = '0;
  int          sent      = 0;
  bit          calm      = 1'b0;
  int          long_hold = 0;

  firmware_page_assembler_core #(
    .PAGE_WORDS(PAGE_WORDS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  flash_command_checker #(
    .PAGE_WORDS(PAGE_WORDS)
  ) flash_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(64'd4_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // Result sink: random stalls, the occasional long hold-off, steady ready when calm.
  initial begin : sink
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold != 0) begin
        n         = long_hold;
        long_hold = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // Offers one transaction; returns at the edge where it was taken, or after a random idle gap when not calm.
  task automatic post_event(input logic [1:0] op, input logic [31:0] word,
                            input logic [31:0] off);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {off, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    case (op)
      OP_START: begin
        sess_open = 1'b1;
        next_off  = '0;
      end
      OP_WRITE: if (sess_open && off == next_off) next_off = next_off + 32'd4;
      OP_END:   sess_open = 1'b0;
      default: ;
    endcase
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic good_write(input logic [31:0] word);
    post_event(OP_WRITE, word, next_off);
  endtask

  task automatic bad_write(input logic [31:0] word);
    logic [31:0] off;
    off = $urandom;
    if (sess_open && off == next_off) off = ~off;
    post_event(OP_WRITE, word, off);
  endtask

  // Stops offering and waits until every predicted result has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_base(input logic [31:0] v);
    drain();
    if (sess_open) next_off = next_off + base_now - v;
    base_now = v;
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_session();
    int n;
    int r;
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 12);
    if (!sess_open || $urandom_range(0, 3) != 0) post_event(OP_START, $urandom, $urandom);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        bad_write($urandom);
      end else if (r == 1) begin
        post_event(OP_UNUSED, $urandom, $urandom);
      end else if (r == 2) begin
        post_event(OP_START, $urandom, $urandom);
      end else begin
        good_write($urandom);
      end
    end
    if ($urandom_range(0, 3) != 0) post_event(OP_END, $urandom, $urandom);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no session, empty end, unused code, then a session near the top of memory.
    post_event(OP_WRITE, 32'hFFFF_FFFF, 32'h0000_0000);
    post_event(OP_END, 32'h0000_0000, 32'hFFFF_FFFF);
    post_event(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_base(32'hFFFF_FFC0);
    post_event(OP_START, 32'h0000_0000, 32'h0000_0000);
    good_write(32'hFFFF_FFFF);
    post_event(OP_WRITE, 32'h1234_5678, next_off + 32'd4);
    good_write(32'h0000_0000);
    post_event(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
    // Restart drops the buffered words; the padded flush then wraps past address zero.
    post_event(OP_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    good_write(32'hA5A5_A5A5);
    good_write(32'h5A5A_5A5A);
    post_event(OP_END, 32'hFFFF_FFFF, 32'h0000_0000);
    post_event(OP_START, 32'h0000_0000, 32'h0000_0000);
    post_event(OP_END, 32'h0000_0000, 32'h0000_0000);
    post_event(OP_WRITE, 32'hDEAD_BEEF, 32'h0000_0000);
    // Base changed in the middle of a session shifts the expected offset.
    load_base(32'hFFFF_FFFF);
    post_event(OP_START, 32'h0000_0000, 32'h0000_0000);
    good_write(32'h0123_4567);
    load_base(32'h0000_0000);
    good_write(32'h89AB_CDEF);
    post_event(OP_END, 32'h0000_0000, 32'h0000_0000);

    // Hold the sink off while a full page and more is offered, so the input backs up.
    load_base(32'h0800_0000);
    post_event(OP_START, $urandom, $urandom);
    long_hold = 300;
    repeat (PAGE_WORDS + 3) good_write($urandom);
    post_event(OP_END, $urandom, $urandom);

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 4))
          0:       load_base(32'h0000_0000);
          1:       load_base(32'hFFFF_FFFF);
          2:       load_base(32'hFFFF_FF80);
          3:       load_base($urandom & 32'hFFFF_FFFC);
          default: load_base($urandom);
        endcase
      end else begin
        drain();
      end
      if ($urandom_range(0, 5) == 0) begin
        // Noise: writes with no session open.
        if (sess_open) post_event(OP_END, $urandom, $urandom);
        repeat ($urandom_range(1, 4)) post_event(OP_WRITE, $urandom, $urandom);
      end else begin
        random_session();
      end
      calm = (sent > RANDOM_ITEMS * 3 / 4);
    end

    drain();
    repeat (PAGE_WORDS + 8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
